// ----- src/rpgs_pkg.sv -----
// Package for the row profile gap segmenter.
// Holds the shared field widths, constants, beat structs and the saturating run increment.
// Depends on nothing; every module of the block imports it.
package rpgs_pkg;

   localparam int PIXEL_W = 8;
   localparam int MARK_W  = 14;
   localparam int RUN_W   = 13;
   localparam int LIMIT_W = 12;

   localparam logic [PIXEL_W-1:0] WHITE_PIXEL = 8'd255;
   localparam logic [MARK_W-1:0]  PAD         = 14'd3;
   localparam logic [RUN_W-1:0]   RUN_MAX     = 13'd8191;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd10;

   typedef logic signed [MARK_W-1:0] mark_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               row_end;
      logic               image_end;
   } item_type;

   typedef struct packed {
      mark_type start_mark;
      mark_type end_mark;
   } mark_pair_type;

   function automatic logic [RUN_W-1:0] run_inc(input logic [RUN_W-1:0] v);
      run_inc = (v == RUN_MAX) ? v : v + 1'b1;
   endfunction

endpackage

// ----- src/rpgs_row_fsm.sv -----
// Row state machine of the row profile gap segmenter: white/black zone, run counters,
// row index, the gap limit register and the band mark arithmetic.
// Depends on rpgs_pkg.
module rpgs_row_fsm #(
   parameter int MAX_ROWS = 4096
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_en,
   input  logic [rpgs_pkg::LIMIT_W-1:0] csr_write_data,
   input  logic                        item_valid,
   input  rpgs_pkg::item_type          item,
   input  logic                        buf_free,
   output logic                        fire,
   output logic                        push,
   output rpgs_pkg::mark_pair_type     pair
);
   import rpgs_pkg::*;

   localparam int ROW_W = $clog2(MAX_ROWS);
   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAX_ROWS - 1);

   logic [LIMIT_W-1:0] limit_ff;
   logic               zone_ff, zone_in;
   logic [RUN_W-1:0]   black_ff, black_in;
   logic [RUN_W-1:0]   white_ff, white_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic               all_white_ff, all_white_in;

   logic               white_now;
   logic               row_done;
   logic               over_limit;
   logic               emit;
   logic [MARK_W-1:0]  r14;

   generate
      if (ROW_W >= MARK_W) begin : g_row_trunc
         assign r14 = row_ff[MARK_W-1:0];
      end else begin : g_row_ext
         assign r14 = {{(MARK_W-ROW_W){1'b0}}, row_ff};
      end
   endgenerate

   assign white_now  = all_white_ff && (item.pixel == WHITE_PIXEL);
   assign row_done   = item.row_end || item.image_end;
   assign over_limit = white_ff > {1'b0, limit_ff};
   assign emit       = row_done && !zone_ff && white_now && (over_limit || item.image_end);
   assign fire       = item_valid && (!emit || buf_free);
   assign push       = fire && emit;

   // Marks wrap to 14 bits, so the subtraction is done at that width.
   always_comb begin
      pair.start_mark = mark_type'(r14 - {1'b0, black_ff} - PAD);
      if (over_limit) begin
         pair.end_mark = mark_type'(r14 - {2'b00, limit_ff} + PAD);
      end else begin
         pair.end_mark = mark_type'(r14 - {1'b0, white_ff} + PAD);
      end
   end

   always_comb begin
      zone_in      = zone_ff;
      black_in     = black_ff;
      white_in     = white_ff;
      row_in       = row_ff;
      all_white_in = white_now;
      if (row_done) begin
         if (zone_ff) begin
            if (white_now) begin
               white_in = run_inc(white_ff);
            end else begin
               black_in = RUN_W'(1);
               white_in = '0;
               zone_in  = 1'b0;
            end
         end else if (!white_now) begin
            white_in = '0;
            black_in = run_inc(black_ff);
         end else if (over_limit) begin
            black_in = '0;
            zone_in  = 1'b1;
         end else if (!item.image_end) begin
            black_in = run_inc(black_ff);
            white_in = run_inc(white_ff);
         end
         all_white_in = 1'b1;
         if (item.image_end) begin
            zone_in  = 1'b1;
            black_in = '0;
            white_in = '0;
            row_in   = '0;
         end else if (row_ff < ROW_LAST) begin
            row_in = row_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RESET;
         zone_ff      <= 1'b1;
         black_ff     <= '0;
         white_ff     <= '0;
         row_ff       <= '0;
         all_white_ff <= 1'b1;
      end else begin
         if (csr_write_en) begin
            limit_ff <= csr_write_data;
         end
         if (fire) begin
            zone_ff      <= zone_in;
            black_ff     <= black_in;
            white_ff     <= white_in;
            row_ff       <= row_in;
            all_white_ff <= all_white_in;
         end
      end
   end

`ifndef NO_ASSERTIONS
   a_image_end_clears: assert property (@(posedge clock) disable iff (reset)
      fire && item.image_end |=> zone_ff && all_white_ff && (row_ff == '0)
         && (black_ff == '0) && (white_ff == '0))
      else $error("state not cleared after image end");
   a_band_returns_white: assert property (@(posedge clock) disable iff (reset)
      push |=> zone_ff)
      else $error("band closed but zone stayed black");
   a_black_zone_has_run: assert property (@(posedge clock) disable iff (reset)
      !zone_ff |-> black_ff != '0)
      else $error("black zone with empty black run");
`endif

endmodule

// ----- src/rpgs_mark_buffer.sv -----
// Result buffer of the row profile gap segmenter: holds one start/end mark pair and
// hands it out as two beats. Depends on rpgs_pkg.
module rpgs_mark_buffer (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  rpgs_pkg::mark_pair_type pair,
   output logic                    buf_free,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output rpgs_pkg::mark_type      rsp_mark_row,
   output logic                    rsp_is_band_end
);
   import rpgs_pkg::*;

   logic [1:0]    cnt_ff, cnt_in;
   mark_pair_type pair_ff;
   logic          pop;

   assign rsp_valid       = cnt_ff != 2'd0;
   assign pop             = rsp_valid && rsp_ready;
   assign buf_free        = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_ready);
   assign rsp_mark_row    = (cnt_ff == 2'd2) ? pair_ff.start_mark : pair_ff.end_mark;
   assign rsp_is_band_end = cnt_ff == 2'd1;

   always_comb begin
      if (push) begin
         cnt_in = 2'd2;
      end else if (pop) begin
         cnt_in = cnt_ff - 2'd1;
      end else begin
         cnt_in = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         pair_ff <= pair;
      end
   end

`ifndef NO_ASSERTIONS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("mark count out of range");
   a_push_when_free: assert property (@(posedge clock) disable iff (reset)
      push |-> buf_free)
      else $error("mark pair pushed over a pending pair");
   a_push_loads_pair: assert property (@(posedge clock) disable iff (reset)
      push |=> (cnt_ff == 2'd2) && !rsp_is_band_end)
      else $error("pushed pair not presented as start mark");
`endif

endmodule

// ----- src/row_profile_gap_segmenter.sv -----
// Top level of the row profile gap segmenter: input register, row state machine and
// mark pair buffer. Depends on rpgs_pkg, rpgs_row_fsm and rpgs_mark_buffer.
//
//   Channel   Ports                                          Direction
//   req       req_valid/ready, pixel, row_end, image_end     in,  one pixel per beat
//   rsp       rsp_valid/ready, mark_row, is_band_end         out, one band mark per beat
//   csr       csr_write_en, csr_write_data (gap limit)       in,  write only
//
// One pixel is taken per clock unless a closing row stalls. A pixel is held in the input
// register, and the row state is updated as it leaves; a closing band puts two marks into
// the result buffer; it shows the start mark in the next cycle, the end mark once it is taken.
// Pixels that close no band keep flowing while a mark pair waits; only a second closing
// row stalls, until the pending end mark is taken. Synchronous reset clears all control
// state and loads the gap limit with 10; no clearing pass is needed.
module row_profile_gap_segmenter #(
   parameter int MAX_ROWS = 4096
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [rpgs_pkg::PIXEL_W-1:0] req_pixel,
   input  logic                         req_row_end,
   input  logic                         req_image_end,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output rpgs_pkg::mark_type           rsp_mark_row,
   output logic                         rsp_is_band_end,
   input  logic                         csr_write_en,
   input  logic [rpgs_pkg::LIMIT_W-1:0] csr_write_data
);
   import rpgs_pkg::*;

   // Input register: holds one accepted pixel beat until the state machine consumes it.
   logic          in_valid_ff;
   item_type      item_ff;
   logic          fire;
   logic          push;
   logic          buf_free;
   mark_pair_type pair;
   logic          accept;

   // The input register is free when empty or when its beat is consumed this cycle.
   assign req_ready = !in_valid_ff || fire;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (accept) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.pixel     <= req_pixel;
         item_ff.row_end   <= req_row_end;
         item_ff.image_end <= req_image_end;
      end
   end

   // Row closing logic: decides at each row end or image end whether a band is complete.
   rpgs_row_fsm #(
      .MAX_ROWS(MAX_ROWS)
   ) u_row_fsm (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .item_valid     (in_valid_ff),
      .item           (item_ff),
      .buf_free       (buf_free),
      .fire           (fire),
      .push           (push),
      .pair           (pair)
   );

   // Result side: the mark pair leaves as a start beat followed by an end beat.
   rpgs_mark_buffer u_mark_buffer (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .pair            (pair),
      .buf_free        (buf_free),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_mark_row    (rsp_mark_row),
      .rsp_is_band_end (rsp_is_band_end)
   );

`ifndef NO_ASSERTIONS
   a_fire_needs_item: assert property (@(posedge clock) disable iff (reset)
      fire |-> in_valid_ff)
      else $error("state machine consumed an empty input register");
   a_stall_keeps_item: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !fire |=> in_valid_ff && $stable(item_ff))
      else $error("stalled pixel beat lost or changed");
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ready)
      else $error("empty input register not ready");
`endif

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for row_profile_gap_segmenter: drives pixel beats, predicts band marks.
// Depends on rpgs_pkg and the row_profile_gap_segmenter RTL; nothing else is read.
// Random images, then directed corners, then random images under four idle and stall patterns.
module tb;

   import rpgs_pkg::*;

   localparam int ROW_LIMIT = 4096;

   // Predicts the band marks of the block from the accepted pixels and holds them until they
   // come out of the result channel.
   class band_mark_board;
      typedef struct {
         mark_type row;
         logic     band_end;
      } mark_beat_type;

      logic [LIMIT_W-1:0] gap_limit;
      bit                 in_white_zone;
      logic [RUN_W-1:0]   black_run;
      logic [RUN_W-1:0]   white_run;
      logic [RUN_W-1:0]   row_index;
      bit                 row_white;
      mark_beat_type      pending_marks[$];
      int                 errors;
      int                 marks_seen;

      function new();
         gap_limit  = LIMIT_RESET;
         errors     = 0;
         marks_seen = 0;
         clear_image();
      endfunction

      function void clear_image();
         in_white_zone = 1'b1;
         black_run     = '0;
         white_run     = '0;
         row_index     = '0;
         row_white     = 1'b1;
      endfunction

      function logic [RUN_W-1:0] sat_inc(input logic [RUN_W-1:0] v);
         return (v == '1) ? v : v + 1'b1;
      endfunction

      // The mark keeps its low 14 bits, so a value past the range wraps.
      function void push_mark(input int value, input logic band_end);
         mark_beat_type m;
         m.row      = value[MARK_W-1:0];
         m.band_end = band_end;
         pending_marks.insert(pending_marks.size(), m);
      endfunction

      function void note_pixel(input logic [PIXEL_W-1:0] pixel, input logic row_end,
                               input logic image_end);
         int r;
         bit white;
         if (pixel != WHITE_PIXEL) row_white = 1'b0;
         if (!(row_end || image_end)) return;
         r     = int'(row_index);
         white = row_white;
         if (in_white_zone) begin
            if (white) begin
               white_run = sat_inc(white_run);
            end else begin
               black_run     = RUN_W'(1);
               white_run     = '0;
               in_white_zone = 1'b0;
            end
         end else if (!white) begin
            white_run = '0;
            black_run = sat_inc(black_run);
         end else if (white_run > gap_limit) begin
            push_mark(r - int'(black_run) - 3, 1'b0);
            push_mark(r - int'(gap_limit) + 3, 1'b1);
            black_run     = '0;
            in_white_zone = 1'b1;
         end else if (image_end) begin
            // The band is cut short by the end of the image on a white row.
            push_mark(r - int'(black_run) - 3, 1'b0);
            push_mark(r - int'(white_run) + 3, 1'b1);
         end else begin
            black_run = sat_inc(black_run);
            white_run = sat_inc(white_run);
         end
         if (image_end) begin
            clear_image();
         end else begin
            row_white = 1'b1;
            if (row_index < ROW_LIMIT - 1) row_index = row_index + 1'b1;
         end
      endfunction

      function void check_mark(input mark_type row, input logic band_end);
         mark_beat_type m;
         if (pending_marks.size() == 0) begin
            $error("unexpected band mark: mark_row %0d, is_band_end %0b", row, band_end);
            errors++;
            return;
         end
         m = pending_marks.pop_front();
         marks_seen++;
         if (row !== m.row) begin
            $error("mark_row: expected %0d, actual %0d", m.row, row);
            errors++;
         end
         if (band_end !== m.band_end) begin
            $error("is_band_end: expected %0b, actual %0b", m.band_end, band_end);
            errors++;
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [PIXEL_W-1:0]   req_pixel = '0;
   logic                 req_row_end = 1'b0;
   logic                 req_image_end = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   mark_type             rsp_mark_row;
   logic                 rsp_is_band_end;
   logic                 csr_write_en = 1'b0;
   logic [LIMIT_W-1:0]   csr_write_data = LIMIT_RESET;

   band_mark_board board;
   int send_idle   = 0;
   int recv_stall  = 0;
   int pixels_sent = 0;

   row_profile_gap_segmenter #(
      .MAX_ROWS(ROW_LIMIT)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel      (req_pixel),
      .req_row_end    (req_row_end),
      .req_image_end  (req_image_end),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_mark_row   (rsp_mark_row),
      .rsp_is_band_end(rsp_is_band_end),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always #6 clock = ~clock;

   // The receiver stalls at random with the current stall rate.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall);
   end

   // Beats are sampled at the edge that accepts them, so the values seen are the settled ones.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) board.note_pixel(req_pixel, req_row_end, req_image_end);
         if (rsp_valid && rsp_ready) board.check_mark(rsp_mark_row, rsp_is_band_end);
      end
   end

   // Offers one pixel beat, after a random gap, and returns at the edge that accepts it.
   task automatic send_pixel(input logic [PIXEL_W-1:0] pixel, input logic row_end,
                             input logic image_end);
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle);
      end
      req_valid     <= 1'b1;
      req_pixel     <= pixel;
      req_row_end   <= row_end;
      req_image_end <= image_end;
      do @(posedge clock); while (!req_ready);
      pixels_sent++;
   endtask

   // A black row gets at least one pixel below 255; the image end sometimes comes without
   // a row end on the same beat.
   task automatic send_row(input bit white, input bit last);
      int width;
      int k;
      int black_at;
      logic [PIXEL_W-1:0] px;
      logic re;
      logic ie;
      width    = ($urandom_range(15) == 0) ? $urandom_range(6, 24) : $urandom_range(1, 4);
      black_at = $urandom_range(0, width - 1);
      for (k = 0; k < width; k++) begin
         if (white) px = WHITE_PIXEL;
         else if (k == black_at) px = 8'($urandom_range(0, 254));
         else px = ($urandom_range(1) != 0) ? WHITE_PIXEL : 8'($urandom_range(255));
         ie = last && (k == width - 1);
         re = (k == width - 1) && !(ie && $urandom_range(4) == 0);
         send_pixel(px, re, ie);
      end
   endtask

   // Mostly well-formed images of alternating black bands and white gaps whose lengths
   // straddle the gap limit when it is at most 12; one in ten is a stream of random beats.
   task automatic send_image();
      int rows;
      int seg_left;
      int cap;
      int k;
      int n;
      bit white;
      if ($urandom_range(9) == 0) begin
         n = $urandom_range(1, 30);
         for (k = 0; k < n; k++) begin
            send_pixel(($urandom_range(1) != 0) ? WHITE_PIXEL : 8'($urandom_range(255)),
                       $urandom_range(2) == 0, k == n - 1);
         end
         return;
      end
      cap      = (board.gap_limit > 12) ? 6 : int'(board.gap_limit);
      rows     = $urandom_range(1, 40);
      white    = 1'($urandom_range(1));
      seg_left = 0;
      for (k = 0; k < rows; k++) begin
         if (seg_left == 0) begin
            white    = !white;
            seg_left = white ? $urandom_range(0, cap + 3) : $urandom_range(1, 4);
            if (seg_left == 0) begin
               white    = !white;
               seg_left = $urandom_range(1, 4);
            end
         end
         send_row(white, k == rows - 1);
         seg_left--;
      end
   endtask

   // Holds the sender off until every predicted mark has come out, then lets the pipeline
   // empty of pixels that close nothing.
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending_marks.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] value);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      board.gap_limit = value;
   endtask

   initial begin
      int p;
      int k;
      int stop_at;
      board = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // A few images under the reset value of the gap limit.
      stop_at = pixels_sent + 80;
      while (pixels_sent < stop_at) send_image();
      wait_idle();
      write_limit(12'd5);

      // Band closed by the white run, then an image end without a row end on a black pixel.
      send_pixel(8'd0, 1'b1, 1'b0);
      for (k = 0; k < 7; k++) send_pixel(WHITE_PIXEL, 1'b1, 1'b0);
      send_pixel(8'd128, 1'b0, 1'b1);
      // Band cut short by the image end on a white row.
      send_pixel(WHITE_PIXEL, 1'b0, 1'b0);
      send_pixel(8'd254, 1'b1, 1'b0);
      send_pixel(WHITE_PIXEL, 1'b0, 1'b0);
      send_pixel(WHITE_PIXEL, 1'b1, 1'b1);
      // Band still open at the image end on a black row: no marks.
      send_pixel(8'd127, 1'b1, 1'b0);
      send_pixel(8'd0, 1'b1, 1'b0);
      send_pixel(8'd1, 1'b1, 1'b1);
      // All-white image with the image end alone.
      send_pixel(WHITE_PIXEL, 1'b0, 1'b0);
      send_pixel(WHITE_PIXEL, 1'b0, 1'b1);
      wait_idle();

      // Largest gap limit: the band can only be cut short by the image end.
      write_limit(12'd4095);
      send_pixel(8'd0, 1'b1, 1'b0);
      for (k = 0; k < 4; k++) send_pixel(WHITE_PIXEL, 1'b1, k == 3);
      wait_idle();

      // Random images: no idling, sender idle, receiver stalling, then both.
      for (p = 0; p < 4; p++) begin
         case (p)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 84; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 84; end
            default: begin send_idle = 26; recv_stall = 26; end
         endcase
         write_limit((p == 0) ? 12'd5 : 12'($urandom_range(5, 12)));
         stop_at = pixels_sent + 110;
         while (pixels_sent < stop_at) send_image();
         // The sender waits here until every mark has come out.
         wait_idle();
         write_limit((p == 2) ? 12'($urandom_range(5, 4095)) : 12'($urandom_range(5, 14)));
         stop_at = pixels_sent + 110;
         while (pixels_sent < stop_at) send_image();
         wait_idle();
      end

      recv_stall = 0;
      repeat (20) @(posedge clock);
      $display("Sent %0d pixels and checked %0d band marks under four idle patterns,",
               pixels_sent, board.marks_seen);
      $display("with gap limits from 5 to 4095, cut-short bands and lone image ends.");
      if (board.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #24000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ----- files.f -----
src/rpgs_pkg.sv
src/rpgs_row_fsm.sv
src/rpgs_mark_buffer.sv
src/row_profile_gap_segmenter.sv
sim/tb.sv
